### rtl/top_k_peak_tracker_assert.svh
// Assertion macros used by the peak tracker controller.
`ifndef TOP_K_PEAK_TRACKER_ASSERT_SVH
`define TOP_K_PEAK_TRACKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TKPT_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TKPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tkpt_pkg.sv
// Shared types and constants of the top-k peak tracker.
package tkpt_pkg;

    localparam int KLIMIT_W = 5;
    localparam logic [KLIMIT_W-1:0] KLIMIT_RESET = 5'd16;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_ROOT_CMP,
        S_DN_L,
        S_DN_R,
        S_DN_CMP,
        S_POP_RD,
        S_POP_TOP,
        S_POP_LAST,
        S_EMIT,
        S_EMPTY
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_ACCEPT_APPEND,
        CMD_ACCEPT_KEEP,
        CMD_READ_ROOT,
        CMD_READ_PARENT,
        CMD_PUT_CUR,
        CMD_MOVE_UP,
        CMD_READ_LEFT,
        CMD_READ_RIGHT,
        CMD_LATCH_LEFT,
        CMD_MOVE_DOWN,
        CMD_TAKE_TOP,
        CMD_TAKE_LAST,
        CMD_EMIT_TOP,
        CMD_EMIT_EMPTY
    } cmd_t;

    typedef struct packed {
        logic in_drain;
        logic count_zero;
        logic count_one;
        logic below_limit;
        logic idx_zero;
        logic up_stop;
        logic root_beaten;
        logic left_in;
        logic right_in;
        logic dn_stop;
        logic out_free;
    } status_t;

endpackage

### rtl/tkpt_dp.sv
// Datapath of the peak tracker: heap memory, sift registers, count and output register.
module tkpt_dp #(
    parameter int CAPACITY = 16,
    parameter int POS_BITS = 16,
    parameter int MAG_BITS = 32,
    parameter int S_W      = 48,
    parameter int M_W      = 48
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tkpt_pkg::cmd_t                cmd,
    input  logic [tkpt_pkg::KLIMIT_W-1:0] k_limit,
    output tkpt_pkg::status_t             st,
    input  logic [S_W-1:0]                s_tdata,
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [M_W-1:0]                m_tdata,
    output logic                          m_tlast,
    output logic                          m_tuser
);

    localparam int EW = POS_BITS + MAG_BITS;
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = IW + 2;
    localparam int LW = (CW > tkpt_pkg::KLIMIT_W) ? CW : tkpt_pkg::KLIMIT_W;

    logic [EW-1:0] mem [CAPACITY];

    logic [EW-1:0] cur_reg, cur_next;
    logic [EW-1:0] rd_data_reg;
    logic [EW-1:0] child_reg, child_next;
    logic [EW-1:0] top_reg, top_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [CW-1:0] count_reg, count_next;
    logic          has_right_reg, has_right_next;
    logic [EW-1:0] out_data_reg, out_data_next;
    logic          out_last_reg, out_last_next;
    logic          out_none_reg, out_none_next;
    logic          out_valid_reg, out_valid_next;

    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    logic [EW-1:0]       in_entry;
    logic [IW-1:0]       parent_idx;
    logic [XW-1:0]       left_x;
    logic [XW-1:0]       right_x;
    logic [XW-1:0]       count_x;
    logic                right_better;
    logic [EW-1:0]       pick_entry;
    logic [IW-1:0]       pick_idx;
    logic [LW-1:0]       k_ext;
    logic [LW-1:0]       eff_limit;
    logic [LW-1:0]       count_l;
    logic [CW-1:0]       count_dec;
    logic [MAG_BITS-1:0] cur_mag;
    logic [MAG_BITS-1:0] rd_mag;
    logic [MAG_BITS-1:0] child_mag;
    logic [MAG_BITS-1:0] pick_mag;

    assign in_entry   = {s_tdata[POS_BITS +: MAG_BITS], s_tdata[POS_BITS-1:0]};
    assign cur_mag    = cur_reg[EW-1:POS_BITS];
    assign rd_mag     = rd_data_reg[EW-1:POS_BITS];
    assign child_mag  = child_reg[EW-1:POS_BITS];
    assign parent_idx = IW'(idx_reg - 1'b1) >> 1;
    assign left_x     = {1'b0, idx_reg, 1'b1};
    assign right_x    = left_x + XW'(1);
    assign count_x    = XW'(count_reg);
    assign count_dec  = count_reg - CW'(1);

    assign right_better = has_right_reg && (rd_mag < child_mag);
    assign pick_entry   = right_better ? rd_data_reg : child_reg;
    assign pick_mag     = pick_entry[EW-1:POS_BITS];
    assign pick_idx     = left_x[IW-1:0] + IW'(right_better);

    assign k_ext   = LW'(k_limit);
    assign count_l = LW'(count_reg);

    always_comb begin
        if (k_ext == '0) begin
            eff_limit = LW'(1);
        end else if (k_ext > LW'(CAPACITY)) begin
            eff_limit = LW'(CAPACITY);
        end else begin
            eff_limit = k_ext;
        end
    end

    always_comb begin
        st.in_drain    = (s_tuser == tkpt_pkg::OP_DRAIN);
        st.count_zero  = (count_reg == '0);
        st.count_one   = (count_reg == CW'(1));
        st.below_limit = (count_l < eff_limit);
        st.idx_zero    = (idx_reg == '0);
        st.up_stop     = (rd_mag <= cur_mag);
        st.root_beaten = (cur_mag > rd_mag);
        st.left_in     = (left_x < count_x);
        st.right_in    = (right_x < count_x);
        st.dn_stop     = (cur_mag <= pick_mag);
        st.out_free    = !out_valid_reg || m_tready;
    end

    always_comb begin
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = cur_reg;
        cur_next       = cur_reg;
        child_next     = child_reg;
        top_next       = top_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        has_right_next = has_right_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_none_next  = out_none_reg;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (cmd)
            tkpt_pkg::CMD_NONE: begin
            end
            tkpt_pkg::CMD_ACCEPT_APPEND: begin
                cur_next   = in_entry;
                idx_next   = count_reg[IW-1:0];
                count_next = count_reg + CW'(1);
            end
            tkpt_pkg::CMD_ACCEPT_KEEP: begin
                cur_next = in_entry;
                idx_next = '0;
                rd_en    = 1'b1;
                rd_addr  = '0;
            end
            tkpt_pkg::CMD_READ_ROOT: begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            tkpt_pkg::CMD_READ_PARENT: begin
                rd_en   = 1'b1;
                rd_addr = parent_idx;
            end
            tkpt_pkg::CMD_PUT_CUR: begin
                wr_en = 1'b1;
            end
            tkpt_pkg::CMD_MOVE_UP: begin
                wr_en    = 1'b1;
                wr_data  = rd_data_reg;
                idx_next = parent_idx;
            end
            tkpt_pkg::CMD_READ_LEFT: begin
                rd_en   = 1'b1;
                rd_addr = left_x[IW-1:0];
            end
            tkpt_pkg::CMD_READ_RIGHT: begin
                child_next     = rd_data_reg;
                has_right_next = 1'b1;
                rd_en          = 1'b1;
                rd_addr        = right_x[IW-1:0];
            end
            tkpt_pkg::CMD_LATCH_LEFT: begin
                child_next     = rd_data_reg;
                has_right_next = 1'b0;
            end
            tkpt_pkg::CMD_MOVE_DOWN: begin
                wr_en    = 1'b1;
                wr_data  = pick_entry;
                idx_next = pick_idx;
            end
            tkpt_pkg::CMD_TAKE_TOP: begin
                top_next = rd_data_reg;
                rd_en    = 1'b1;
                rd_addr  = count_dec[IW-1:0];
                if (count_reg == CW'(1)) begin
                    count_next = '0;
                end
            end
            tkpt_pkg::CMD_TAKE_LAST: begin
                cur_next   = rd_data_reg;
                count_next = count_dec;
                idx_next   = '0;
            end
            tkpt_pkg::CMD_EMIT_TOP: begin
                out_data_next  = top_reg;
                out_last_next  = (count_reg == '0);
                out_none_next  = 1'b0;
                out_valid_next = 1'b1;
            end
            tkpt_pkg::CMD_EMIT_EMPTY: begin
                out_data_next  = '0;
                out_last_next  = 1'b1;
                out_none_next  = 1'b1;
                out_valid_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        child_reg     <= child_next;
        top_reg       <= top_next;
        idx_reg       <= idx_next;
        has_right_reg <= has_right_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
        out_none_reg  <= out_none_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_W'(out_data_reg);
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_none_reg;

endmodule

### rtl/tkpt_ctrl.sv
// Controller of the peak tracker: sequencing state machine and the k_limit register.
`include "top_k_peak_tracker_assert.svh"

module tkpt_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tkpt_pkg::KLIMIT_W-1:0] cfg_data,
    output logic [tkpt_pkg::KLIMIT_W-1:0] k_limit,
    input  tkpt_pkg::status_t             st,
    output tkpt_pkg::cmd_t                cmd
);

    tkpt_pkg::state_t              state_reg, state_next;
    logic                          drain_reg, drain_next;
    logic [tkpt_pkg::KLIMIT_W-1:0] k_limit_reg;
    logic                          accept;

    assign accept    = s_tvalid && (state_reg == tkpt_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign k_limit   = k_limit_reg;

    always_comb begin
        state_next = state_reg;
        drain_next = drain_reg;
        unique case (state_reg)
            tkpt_pkg::S_IDLE: begin
                if (accept) begin
                    drain_next = st.in_drain;
                    priority if (st.in_drain && st.count_zero) begin
                        state_next = tkpt_pkg::S_EMPTY;
                    end else if (st.in_drain) begin
                        state_next = tkpt_pkg::S_POP_TOP;
                    end else if (st.below_limit) begin
                        state_next = tkpt_pkg::S_UP_RD;
                    end else if (!st.count_zero) begin
                        state_next = tkpt_pkg::S_ROOT_CMP;
                    end else begin
                        state_next = tkpt_pkg::S_IDLE;
                    end
                end
            end
            tkpt_pkg::S_UP_RD: begin
                state_next = st.idx_zero ? tkpt_pkg::S_IDLE : tkpt_pkg::S_UP_CMP;
            end
            tkpt_pkg::S_UP_CMP: begin
                state_next = st.up_stop ? tkpt_pkg::S_IDLE : tkpt_pkg::S_UP_RD;
            end
            tkpt_pkg::S_ROOT_CMP: begin
                state_next = st.root_beaten ? tkpt_pkg::S_DN_L : tkpt_pkg::S_IDLE;
            end
            tkpt_pkg::S_DN_L: begin
                if (st.left_in) begin
                    state_next = tkpt_pkg::S_DN_R;
                end else begin
                    state_next = drain_reg ? tkpt_pkg::S_EMIT : tkpt_pkg::S_IDLE;
                end
            end
            tkpt_pkg::S_DN_R: begin
                state_next = tkpt_pkg::S_DN_CMP;
            end
            tkpt_pkg::S_DN_CMP: begin
                if (st.dn_stop) begin
                    state_next = drain_reg ? tkpt_pkg::S_EMIT : tkpt_pkg::S_IDLE;
                end else begin
                    state_next = tkpt_pkg::S_DN_L;
                end
            end
            tkpt_pkg::S_POP_RD: begin
                state_next = tkpt_pkg::S_POP_TOP;
            end
            tkpt_pkg::S_POP_TOP: begin
                state_next = st.count_one ? tkpt_pkg::S_EMIT : tkpt_pkg::S_POP_LAST;
            end
            tkpt_pkg::S_POP_LAST: begin
                state_next = tkpt_pkg::S_DN_L;
            end
            tkpt_pkg::S_EMIT: begin
                if (st.out_free) begin
                    state_next = st.count_zero ? tkpt_pkg::S_IDLE : tkpt_pkg::S_POP_RD;
                end
            end
            tkpt_pkg::S_EMPTY: begin
                if (st.out_free) begin
                    state_next = tkpt_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = tkpt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready = (state_reg == tkpt_pkg::S_IDLE);
        cmd      = tkpt_pkg::CMD_NONE;
        unique case (state_reg)
            tkpt_pkg::S_IDLE: begin
                if (accept) begin
                    priority if (st.in_drain && !st.count_zero) begin
                        cmd = tkpt_pkg::CMD_READ_ROOT;
                    end else if (st.in_drain) begin
                        cmd = tkpt_pkg::CMD_NONE;
                    end else if (st.below_limit) begin
                        cmd = tkpt_pkg::CMD_ACCEPT_APPEND;
                    end else if (!st.count_zero) begin
                        cmd = tkpt_pkg::CMD_ACCEPT_KEEP;
                    end else begin
                        cmd = tkpt_pkg::CMD_NONE;
                    end
                end
            end
            tkpt_pkg::S_UP_RD: begin
                cmd = st.idx_zero ? tkpt_pkg::CMD_PUT_CUR : tkpt_pkg::CMD_READ_PARENT;
            end
            tkpt_pkg::S_UP_CMP: begin
                cmd = st.up_stop ? tkpt_pkg::CMD_PUT_CUR : tkpt_pkg::CMD_MOVE_UP;
            end
            tkpt_pkg::S_ROOT_CMP: begin
                cmd = tkpt_pkg::CMD_NONE;
            end
            tkpt_pkg::S_DN_L: begin
                cmd = st.left_in ? tkpt_pkg::CMD_READ_LEFT : tkpt_pkg::CMD_PUT_CUR;
            end
            tkpt_pkg::S_DN_R: begin
                cmd = st.right_in ? tkpt_pkg::CMD_READ_RIGHT : tkpt_pkg::CMD_LATCH_LEFT;
            end
            tkpt_pkg::S_DN_CMP: begin
                cmd = st.dn_stop ? tkpt_pkg::CMD_PUT_CUR : tkpt_pkg::CMD_MOVE_DOWN;
            end
            tkpt_pkg::S_POP_RD: begin
                cmd = tkpt_pkg::CMD_READ_ROOT;
            end
            tkpt_pkg::S_POP_TOP: begin
                cmd = tkpt_pkg::CMD_TAKE_TOP;
            end
            tkpt_pkg::S_POP_LAST: begin
                cmd = tkpt_pkg::CMD_TAKE_LAST;
            end
            tkpt_pkg::S_EMIT: begin
                cmd = st.out_free ? tkpt_pkg::CMD_EMIT_TOP : tkpt_pkg::CMD_NONE;
            end
            tkpt_pkg::S_EMPTY: begin
                cmd = st.out_free ? tkpt_pkg::CMD_EMIT_EMPTY : tkpt_pkg::CMD_NONE;
            end
            default: begin
                cmd = tkpt_pkg::CMD_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tkpt_pkg::S_IDLE;
            drain_reg   <= 1'b0;
            k_limit_reg <= tkpt_pkg::KLIMIT_RESET;
        end else begin
            state_reg <= state_next;
            drain_reg <= drain_next;
            if (cfg_valid && cfg_ready) begin
                k_limit_reg <= cfg_data;
            end
        end
    end

    `TKPT_ASSERT_NEXT(a_drain_leaves_idle, aclk, aresetn, accept && st.in_drain,
        state_reg != tkpt_pkg::S_IDLE, "drain word did not start a pop sequence")
    `TKPT_ASSERT_NEXT(a_klimit_holds, aclk, aresetn, !cfg_valid,
        $stable(k_limit_reg), "k_limit changed without a configuration write")
    `TKPT_ASSERT_SAME(a_idle_quiet, aclk, aresetn,
        (state_reg == tkpt_pkg::S_IDLE) && !accept,
        cmd == tkpt_pkg::CMD_NONE, "datapath commanded while idle")
    `TKPT_ASSERT_SAME(a_emit_free, aclk, aresetn,
        (cmd == tkpt_pkg::CMD_EMIT_TOP) || (cmd == tkpt_pkg::CMD_EMIT_EMPTY),
        st.out_free, "result loaded over an untaken result")

endmodule

### rtl/top_k_peak_tracker.sv
// Top level of the top-k peak tracker: controller and heap datapath.
// An add is either dropped, appended with a sift-up, or written over the root with a sift-down;
// each heap step waits on a registered heap read.
// A drain of n peaks gives n words, smallest magnitude first, and waits while m_tready is low.
// Synchronous active-low reset empties the heap, clears the result valid flag and sets
// k_limit to 16; heap memory contents are not cleared.
module top_k_peak_tracker #(
    parameter int CAPACITY = 16,
    parameter int POS_BITS = 16,
    parameter int MAG_BITS = 32
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // peak_pos, then peak_mag, zero padded to bytes
    input  logic [((POS_BITS + MAG_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // operation
    input  logic                                         s_tuser,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    // out_pos, then out_mag, zero padded to bytes
    output logic [((POS_BITS + MAG_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    output logic                                         m_tlast,
    // none_held
    output logic                                         m_tuser,
    input  logic                                         cfg_valid,
    output logic                                         cfg_ready,
    input  logic [tkpt_pkg::KLIMIT_W-1:0]                cfg_data
);

    localparam int D_W = ((POS_BITS + MAG_BITS + 7) / 8) * 8;

    tkpt_pkg::cmd_t                cmd;
    tkpt_pkg::status_t             st;
    logic [tkpt_pkg::KLIMIT_W-1:0] k_limit;

    tkpt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .k_limit   (k_limit),
        .st        (st),
        .cmd       (cmd)
    );

    tkpt_dp #(
        .CAPACITY (CAPACITY),
        .POS_BITS (POS_BITS),
        .MAG_BITS (MAG_BITS),
        .S_W      (D_W),
        .M_W      (D_W)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .k_limit  (k_limit),
        .st       (st),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for top_k_peak_tracker with a heap predictor and random traffic.
module testbench;

    localparam int CAP = 16;
    localparam int POS_W = 16;
    localparam int MAG_W = 32;
    localparam int DATA_W = ((POS_W + MAG_W + 7) / 8) * 8;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS = 30;
    localparam logic OP_ADD = ~tkpt_pkg::OP_DRAIN;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [MAG_W-1:0] mag;
    } peak_t;

    typedef struct packed {
        peak_t peak;
        logic  is_last;
        logic  none_held;
    } drain_word_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [DATA_W-1:0]             s_tdata = '0;
    logic                          s_tuser = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [DATA_W-1:0]             m_tdata;
    logic                          m_tlast;
    logic                          m_tuser;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [tkpt_pkg::KLIMIT_W-1:0] cfg_data = '0;

    peak_t       peak_heap [CAP];
    int          held_count = 0;
    logic [4:0]  k_setting = tkpt_pkg::KLIMIT_RESET;
    drain_word_t expected_words [$];

    int mismatches = 0;
    int words_checked = 0;
    int adds_sent = 0;
    int drains_sent = 0;
    int cfg_writes = 0;
    int burst_left = 0;
    int cycle_count = 0;
    int stall_mode = 0;
    int stall_left = 0;

    top_k_peak_tracker #(
        .CAPACITY(CAP),
        .POS_BITS(POS_W),
        .MAG_BITS(MAG_W)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected", cycle_count,
                     expected_words.size());
            $display("top_k_peak_tracker test failed");
            $finish;
        end
    end

    // The receiver switches between always ready, coin flips, long stalls and a fixed pattern.
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(30, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_tready <= ($urandom_range(0, 7) == 0);
            end
            default: begin
                m_tready <= ((cycle_count % 4) != 3);
            end
        endcase
    end

    function automatic void heap_sift_down(int idx);
        int    pick;
        peak_t held;
        while (2 * idx + 1 < held_count) begin
            pick = 2 * idx + 1;
            if (pick + 1 < held_count && peak_heap[pick + 1].mag < peak_heap[pick].mag)
                pick = pick + 1;
            if (peak_heap[idx].mag <= peak_heap[pick].mag)
                break;
            held = peak_heap[idx];
            peak_heap[idx] = peak_heap[pick];
            peak_heap[pick] = held;
            idx = pick;
        end
    endfunction

    function automatic void predict_peaks(logic op, logic [POS_W-1:0] pos,
                                          logic [MAG_W-1:0] mag);
        int          limit;
        int          idx;
        int          n;
        int          k;
        peak_t       held;
        drain_word_t word;
        if (op == OP_ADD) begin
            limit = (k_setting == 0) ? 1 : (k_setting > CAP) ? CAP : int'(k_setting);
            if (held_count < limit) begin
                idx = held_count;
                peak_heap[idx] = '{pos: pos, mag: mag};
                held_count++;
                while (idx > 0 && peak_heap[(idx - 1) / 2].mag > peak_heap[idx].mag) begin
                    held = peak_heap[idx];
                    peak_heap[idx] = peak_heap[(idx - 1) / 2];
                    peak_heap[(idx - 1) / 2] = held;
                    idx = (idx - 1) / 2;
                end
            end else if (held_count > 0 && mag > peak_heap[0].mag) begin
                peak_heap[0] = '{pos: pos, mag: mag};
                heap_sift_down(0);
            end
        end else if (held_count == 0) begin
            word = '{peak: '0, is_last: 1'b1, none_held: 1'b1};
            expected_words.push_back(word);
        end else begin
            n = held_count;
            for (k = 0; k < n; k++) begin
                if (held_count <= 1) begin
                    held_count = 0;
                    word.peak = peak_heap[0];
                end else begin
                    held = peak_heap[0];
                    peak_heap[0] = peak_heap[held_count - 1];
                    peak_heap[held_count - 1] = held;
                    held_count--;
                    heap_sift_down(0);
                    word.peak = peak_heap[held_count];
                end
                word.is_last = (k == n - 1);
                word.none_held = 1'b0;
                expected_words.push_back(word);
            end
            held_count = 0;
        end
    endfunction

    task automatic note_mismatch(string what, drain_word_t want, drain_word_t got);
        mismatches++;
        if (mismatches <= 10)
            $display({"%0t %s: expected pos %h mag %h last %b empty %b, ",
                      "got pos %h mag %h last %b empty %b"},
                     $time, what, want.peak.pos, want.peak.mag, want.is_last, want.none_held,
                     got.peak.pos, got.peak.mag, got.is_last, got.none_held);
    endtask

    always @(posedge aclk) begin
        drain_word_t got;
        drain_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.peak.pos = m_tdata[POS_W-1:0];
            got.peak.mag = m_tdata[POS_W+MAG_W-1:POS_W];
            got.is_last = m_tlast;
            got.none_held = m_tuser;
            words_checked++;
            if (expected_words.size() == 0) begin
                note_mismatch("unexpected word", '0, got);
            end else begin
                want = expected_words.pop_front();
                if (got.peak.pos !== want.peak.pos || got.peak.mag !== want.peak.mag ||
                    got.is_last !== want.is_last || got.none_held !== want.none_held)
                    note_mismatch("word mismatch", want, got);
            end
        end
    end

    task automatic send_word(logic op, logic [POS_W-1:0] pos, logic [MAG_W-1:0] mag);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                s_tdata <= DATA_W'({$urandom, $urandom});
                s_tuser <= 1'($urandom_range(0, 1));
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {mag, pos};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_peaks(op, pos, mag);
        if (op == OP_ADD)
            adds_sent++;
        else
            drains_sent++;
    endtask

    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_k_limit(logic [4:0] value);
        wait_quiet();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        k_setting = value;
        cfg_writes++;
    endtask

    task automatic test_empty_drain();
        send_word(tkpt_pkg::OP_DRAIN, '0, '0);
    endtask

    task automatic test_ties_and_extremes();
        write_k_limit(5'd3);
        send_word(OP_ADD, 16'h0000, 32'h0000_0000);
        send_word(OP_ADD, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(OP_ADD, 16'h1234, 32'd5);
        send_word(OP_ADD, 16'h4321, 32'd5);
        send_word(OP_ADD, 16'h5555, 32'd5);
        send_word(OP_ADD, 16'hAAAA, 32'd4);
        send_word(OP_ADD, 16'h00FF, 32'hFFFF_FFFE);
        send_word(tkpt_pkg::OP_DRAIN, 16'hFFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_zero_limit();
        write_k_limit(5'd0);
        send_word(OP_ADD, 16'h0101, 32'd100);
        send_word(OP_ADD, 16'h0202, 32'd200);
        send_word(tkpt_pkg::OP_DRAIN, '0, '0);
    endtask

    task automatic test_shrink_limit();
        write_k_limit(5'd16);
        send_word(OP_ADD, 16'h0010, 32'd40);
        send_word(OP_ADD, 16'h0020, 32'd10);
        send_word(OP_ADD, 16'h0030, 32'd30);
        send_word(OP_ADD, 16'h0040, 32'd20);
        write_k_limit(5'd2);
        send_word(OP_ADD, 16'h0050, 32'd25);
        send_word(OP_ADD, 16'h0060, 32'd20);
        send_word(tkpt_pkg::OP_DRAIN, '0, '0);
    endtask

    task automatic test_random_phases();
        logic [4:0]       limits [RANDOM_PHASES];
        logic             op;
        logic [POS_W-1:0] pos;
        logic [MAG_W-1:0] mag;
        int               span;
        int               phase;
        int               item;
        limits = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd2, 5'd17, 5'd8, 5'd15, 5'd4, 5'd16};
        limits[8] = 5'($urandom_range(0, 31));
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_k_limit(limits[phase]);
            span = 2 * ((limits[phase] == 0) ? 1 : (limits[phase] > CAP) ? CAP :
                        int'(limits[phase])) + 2;
            for (item = 0; item < PHASE_ITEMS; item++) begin
                op = ($urandom_range(0, span) == 0) ? tkpt_pkg::OP_DRAIN : OP_ADD;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: mag = $urandom;
                    5, 6, 7:       mag = $urandom_range(0, 7);
                    8:             mag = $urandom_range(0, 1) ? '1 : '0;
                    default:       mag = '1 - $urandom_range(0, 3);
                endcase
                case ($urandom_range(0, 7))
                    0:       pos = '0;
                    1:       pos = '1;
                    default: pos = POS_W'($urandom);
                endcase
                send_word(op, pos, mag);
                if ($urandom_range(0, 39) == 0)
                    wait_quiet();
            end
        end
        send_word(tkpt_pkg::OP_DRAIN, POS_W'($urandom), $urandom);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_drain();
        test_ties_and_extremes();
        test_zero_limit();
        test_shrink_limit();
        test_random_phases();
        wait_quiet();
        $display("Run covered %0d adds and %0d drains across %0d k_limit writes.",
                 adds_sent, drains_sent, cfg_writes);
        $display("Checked %0d result words and found %0d mismatches.", words_checked,
                 mismatches);
        if (mismatches == 0) begin
            $display("top_k_peak_tracker test passed");
        end else begin
            $display("top_k_peak_tracker test failed");
        end
        $finish;
    end

endmodule
